// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue unit: word formats of
// both channels, command and status codes, and the pointer-unit control bundle.
// ----------------------------------------------------------------------------
package deq_pkg;

  // default geometry
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the channel words
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REVERSE    = 3'd4,
    CMD_OBSERVE    = 3'd5
  } deq_cmd_e;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } deq_status_e;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] data_in;
  } deq_in_t;

  // result word
  typedef struct packed {
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic [STAT_W-1:0]  status;
  } deq_out_t;

  // control bundle from the pointer unit
  typedef struct packed {
    logic        wr_en;
    logic        is_empty;
    logic        rev;
    deq_status_e status;
  } deq_ctl_t;

endpackage

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_a_addr,
  output logic [WIDTH-1:0]  rd_a_data,
  input  logic [ADDR_W-1:0] rd_b_addr,
  output logic [WIDTH-1:0]  rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== sv/deq_ptr.sv =====
// ----------------------------------------------------------------------------
// deq_ptr
// Ring pointer unit: holds head index, word count and direction flag, decodes
// one command per go strobe, and produces the write slot plus the read slots
// of the first and last stored words.
// ----------------------------------------------------------------------------
module deq_ptr
  import deq_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [CMD_W-1:0]  cmd,
  output deq_ctl_t          ctl,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ADDR_W-1:0] first_addr,
  output logic [ADDR_W-1:0] last_addr,
  output logic [CNT_W-1:0]  count
);

  localparam int SUM_W = ADDR_W + 1;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              rev_r, rev_nxt;

  logic              full, empty, at_front;
  logic [ADDR_W-1:0] head_dec, head_inc, tail_addr, back_addr;
  logic [SUM_W-1:0]  tail_sum, back_sum;
  logic [CNT_W-1:0]  count_m1;

  // ring arithmetic
  always_comb begin
    full     = (count_r == CNT_W'(DEPTH));
    empty    = (count_r == '0);
    head_dec = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - 1'b1;
    head_inc = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    count_m1 = empty ? '0 : count_r - 1'b1;
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    back_sum = SUM_W'(head_r) + SUM_W'(count_m1);
    tail_addr = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                            : tail_sum[ADDR_W-1:0];
    back_addr = (back_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back_sum - SUM_W'(DEPTH))
                                            : back_sum[ADDR_W-1:0];
  end

  // command decode
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    ctl.wr_en  = 1'b0;
    ctl.status = STAT_DONE;
    wr_addr    = tail_addr;
    at_front   = 1'b0;
    unique case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        at_front = ((cmd == CMD_PUSH_FRONT) != rev_r);
        if (full) begin
          ctl.status = STAT_FULL;
        end else begin
          ctl.wr_en = 1'b1;
          count_nxt = count_r + 1'b1;
          if (at_front) begin
            head_nxt = head_dec;
            wr_addr  = head_dec;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        at_front = ((cmd == CMD_POP_FRONT) != rev_r);
        if (empty) begin
          ctl.status = STAT_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          if (at_front) begin
            head_nxt = head_inc;
          end
        end
      end
      CMD_REVERSE: begin
        if (empty) begin
          ctl.status = STAT_EMPTY;
        end else begin
          rev_nxt = ~rev_r;
        end
      end
      default: begin
        // observe and unused codes leave state alone
      end
    endcase
    ctl.wr_en    = ctl.wr_en & go;
    ctl.is_empty = empty;
    ctl.rev      = rev_r;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (go) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  assign first_addr = head_r;
  assign last_addr  = back_addr;
  assign count      = count_r;

endmodule

// ===== sv/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of words held in a ring buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one command word: push front or back,
//   pop front or back, reverse, or observe. Every command returns exactly one
//   result word on out_valid/out_stall/out_data with the front and back
//   words, the count, the empty flag and a status (done, refused because
//   empty, refused because full). Refused commands change nothing.
//   Sequence: an accepted command updates the pointers and writes the RAM,
//   then the first and last slots are read from the registered RAM, and
//   the result is loaded into the output register unless the output
//   register is still held by a stalled earlier result; these steps run
//   in turn, set by the registered RAM read after each write, and a new
//   command is taken only once the result has been loaded.
//   in_stall is high from acceptance until the result has been loaded into
//   the output register; a stalled result holds and a new command may then
//   be taken, its result waiting until the old one is taken.
//   Reset (rst_n low, synchronous) empties the queue, clears the direction
//   flag and drops any pending result; the slot RAM is not cleared, since a
//   slot is read only after it has been written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output deq_out_t out_data
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MW     = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int MCW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  state_t            state_r;
  deq_status_e       status_r;
  logic              out_valid_r;
  deq_out_t          out_r;

  logic              accept, load;
  deq_ctl_t          ctl;
  logic [ADDR_W-1:0] wr_addr, first_addr, last_addr;
  logic [CNT_W-1:0]  count;
  logic [MW-1:0]     wide_in, wide_first, wide_last;
  logic [MCW-1:0]    wide_count;
  logic [DATA_WIDTH-1:0] wr_data, first_data, last_data;
  logic [VALUE_W-1:0]    first_val, last_val;
  deq_out_t          res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign load     = (state_r == ST_SEND) && (!out_valid_r || !out_stall);

  // pointer unit
  deq_ptr #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_ptr (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (accept),
    .cmd        (in_data.cmd),
    .ctl        (ctl),
    .wr_addr    (wr_addr),
    .first_addr (first_addr),
    .last_addr  (last_addr),
    .count      (count)
  );

  // store word masked to the slot width
  always_comb begin
    wide_in = MW'(in_data.data_in);
    wr_data = wide_in[DATA_WIDTH-1:0];
  end

  // slot memory
  deq_ram #(
    .WIDTH  (DATA_WIDTH),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ctl.wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (first_addr),
    .rd_a_data (first_data),
    .rd_b_addr (last_addr),
    .rd_b_data (last_data)
  );

  // result assembly: swap ends when reversed, zero when empty
  always_comb begin
    wide_first = MW'(first_data);
    wide_last  = MW'(last_data);
    wide_count = MCW'(count);
    first_val  = wide_first[VALUE_W-1:0];
    last_val   = wide_last[VALUE_W-1:0];
    if (ctl.is_empty) begin
      res.front_value = '0;
      res.back_value  = '0;
    end else if (ctl.rev) begin
      res.front_value = last_val;
      res.back_value  = first_val;
    end else begin
      res.front_value = first_val;
      res.back_value  = last_val;
    end
    res.entry_count = wide_count[COUNT_W-1:0];
    res.is_empty    = ctl.is_empty;
    res.status      = status_r;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r  <= ST_READ;
            status_r <= ctl.status;
          end
        end
        ST_READ: begin
          state_r <= ST_SEND;
        end
        ST_SEND: begin
          if (load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (load) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // count never runs past the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(DEPTH))
    else $error("word count exceeds ring depth");

  // an accepted command always moves on to the read cycle
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_READ))
    else $error("accepted command did not start its read");

  // a result appears only out of the send step
  a_valid_from_send: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_SEND))
    else $error("result raised outside the send step");

  // a refused command leaves the count unchanged
  a_refuse_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ctl.status != STAT_DONE)) |=> $stable(count))
    else $error("refused command changed the count");
`endif

endmodule
